// File: hdl/sha1sh_pkg.sv
// Shared constants for the SHA-1 stream hasher: initial chaining values,
// round constants and the helper for the round function.
// No dependencies.
package sha1sh_pkg;

   localparam int WordWidth  = 32;
   localparam int CountWidth = 61;
   localparam int NumRounds  = 80;

   localparam logic [WordWidth-1:0] Init0 = 32'h67452301;
   localparam logic [WordWidth-1:0] Init1 = 32'hEFCDAB89;
   localparam logic [WordWidth-1:0] Init2 = 32'h98BADCFE;
   localparam logic [WordWidth-1:0] Init3 = 32'h10325476;
   localparam logic [WordWidth-1:0] Init4 = 32'hC3D2E1F0;

   localparam logic [WordWidth-1:0] K0 = 32'h5A827999;
   localparam logic [WordWidth-1:0] K1 = 32'h6ED9EBA1;
   localparam logic [WordWidth-1:0] K2 = 32'h8F1BBCDC;
   localparam logic [WordWidth-1:0] K3 = 32'hCA62C1D6;

   localparam logic [7:0] PadByte = 8'h80;

   localparam logic FuncAbsorb = 1'b0;
   localparam logic FuncFinish = 1'b1;

   typedef logic [WordWidth-1:0] word_type;

   // Round function and constant, selected by the round number.
   function automatic word_type round_f(input logic [6:0] rnd, input word_type b,
                                        input word_type c, input word_type d);
      if (rnd < 7'd20)
         return (b & c) | (~b & d);
      else if (rnd < 7'd40)
         return b ^ c ^ d;
      else if (rnd < 7'd60)
         return (b & c) | (b & d) | (c & d);
      else
         return b ^ c ^ d;
   endfunction

   function automatic word_type round_k(input logic [6:0] rnd);
      if (rnd < 7'd20)
         return K0;
      else if (rnd < 7'd40)
         return K1;
      else if (rnd < 7'd60)
         return K2;
      else
         return K3;
   endfunction

endpackage

// File: hdl/sha1_stream_hasher.sv
// SHA-1 stream hasher: the byte packer, the block memory, the round engine,
// the padding sequencer and the digest output, all in one module.
// Depends on sha1sh_pkg.
//
// An absorb transfer is taken while the hasher is idle. When it completes a
// 64-byte block the block is compressed: the load state starts the block
// memory read, 80 rounds follow at one round a cycle and the add state adds
// into the chaining words, with req_stall high throughout. The round engine
// and the single read port of the 16-word block memory limit the throughput.
// A finish transfer writes the padding one word a cycle, compresses one or
// two blocks and then offers the five digest words, most significant first,
// with rsp_last_word on the fifth. No new request is taken until the fifth
// word has been transferred; the hash state is then back at its initial
// values.
module sha1_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_last_word
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StPad   = 3'd1;
   localparam logic [2:0] StLoad  = 3'd2;
   localparam logic [2:0] StRound = 3'd3;
   localparam logic [2:0] StAdd   = 3'd4;
   localparam logic [2:0] StOut   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [sha1sh_pkg::CountWidth-1:0] count_ff, count_in;
   sha1sh_pkg::word_type chain_ff [5];
   sha1sh_pkg::word_type chain_in [5];
   sha1sh_pkg::word_type a_ff, b_ff, c_ff, d_ff, e_ff;
   sha1sh_pkg::word_type a_in, b_in, c_in, d_in, e_in;
   logic [15:0][31:0] win_ff, win_in;
   logic [6:0] rnd_ff, rnd_in;
   sha1sh_pkg::word_type word_ff, word_in;
   logic [3:0] pw_ff, pw_in;
   logic       first_ff, first_in;
   logic       len_blk_ff, len_blk_in;
   logic       fin_ff, fin_in;
   logic [2:0] oi_ff, oi_in;

   // Block memory, one write and one registered read port.
   sha1sh_pkg::word_type mem [16];
   sha1sh_pkg::word_type rdata_ff;
   logic                 mem_we;
   logic [3:0]           mem_waddr, mem_raddr;
   sha1sh_pkg::word_type mem_wdata;

   logic [5:0]           pos;
   logic [1:0]           lane;
   logic [4:0]           lane_sh;
   logic [63:0]          bits;
   sha1sh_pkg::word_type first_word, sched_w, w, tmp;
   logic                 req_xfer, rsp_xfer;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != StIdle);
   assign rsp_valid = (state_ff == StOut);
   assign rsp_digest_word = chain_ff[oi_ff];
   assign rsp_last_word = (oi_ff == 3'd4);

   assign pos     = count_ff[5:0];
   assign lane    = pos[1:0];
   assign lane_sh = {lane, 3'b000};
   assign bits    = {count_ff, 3'b000};

   // Pad word: earlier lanes kept, 0x80 at the current lane, zeros after.
   assign first_word = (word_ff & ~(32'hFFFFFFFF >> lane_sh)) |
                       ({sha1sh_pkg::PadByte, 24'h000000} >> lane_sh);

   assign sched_w = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign w       = (rnd_ff < 7'd16) ? rdata_ff : {sched_w[30:0], sched_w[31]};
   assign tmp     = {a_ff[26:0], a_ff[31:27]} +
                    sha1sh_pkg::round_f(rnd_ff, b_ff, c_ff, d_ff) + e_ff + w +
                    sha1sh_pkg::round_k(rnd_ff);

   assign mem_raddr = (state_ff == StRound) ? (rnd_ff[3:0] + 4'd1) : 4'd0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      chain_in   = chain_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      win_in     = win_ff;
      rnd_in     = rnd_ff;
      word_in    = word_ff;
      pw_in      = pw_ff;
      first_in   = first_ff;
      len_blk_in = len_blk_ff;
      fin_in     = fin_ff;
      oi_in      = oi_ff;
      mem_we     = 1'b0;
      mem_waddr  = pos[5:2];
      mem_wdata  = word_ff;

      unique case (state_ff)
         StIdle: begin
            if (req_xfer) begin
               if (req_func == sha1sh_pkg::FuncAbsorb) begin
                  word_in = (word_ff & ~(32'hFF000000 >> lane_sh)) |
                            ({req_data_byte, 24'h000000} >> lane_sh);
                  count_in = count_ff + 1'b1;
                  if (lane == 2'd3) begin
                     mem_we    = 1'b1;
                     mem_wdata = word_in;
                  end
                  if (pos == 6'd63) begin
                     fin_in   = 1'b0;
                     state_in = StLoad;
                  end
               end else begin
                  fin_in     = 1'b1;
                  first_in   = 1'b1;
                  pw_in      = pos[5:2];
                  len_blk_in = (pos < 6'd56);
                  state_in   = StPad;
               end
            end
         end
         StPad: begin
            mem_we    = 1'b1;
            mem_waddr = pw_ff;
            if (first_ff)
               mem_wdata = first_word;
            else if (len_blk_ff && pw_ff == 4'd14)
               mem_wdata = bits[63:32];
            else if (len_blk_ff && pw_ff == 4'd15)
               mem_wdata = bits[31:0];
            else
               mem_wdata = '0;
            first_in = 1'b0;
            pw_in    = pw_ff + 4'd1;
            if (pw_ff == 4'd15) begin
               state_in = StLoad;
            end
         end
         StLoad: begin
            a_in = chain_ff[0]; b_in = chain_ff[1]; c_in = chain_ff[2];
            d_in = chain_ff[3]; e_in = chain_ff[4];
            rnd_in   = '0;
            state_in = StRound;
         end
         StRound: begin
            win_in = {w, win_ff[15:1]};
            e_in = d_ff;
            d_in = c_ff;
            c_in = {b_ff[1:0], b_ff[31:2]};
            b_in = a_ff;
            a_in = tmp;
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'(sha1sh_pkg::NumRounds - 1)) begin
               state_in = StAdd;
            end
         end
         StAdd: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            chain_in[4] = chain_ff[4] + e_ff;
            if (!fin_ff) begin
               state_in = StIdle;
            end else if (len_blk_ff) begin
               oi_in    = '0;
               state_in = StOut;
            end else begin
               len_blk_in = 1'b1;
               pw_in      = '0;
               state_in   = StPad;
            end
         end
         StOut: begin
            if (rsp_xfer) begin
               oi_in = oi_ff + 3'd1;
               if (oi_ff == 3'd4) begin
                  chain_in[0] = sha1sh_pkg::Init0;
                  chain_in[1] = sha1sh_pkg::Init1;
                  chain_in[2] = sha1sh_pkg::Init2;
                  chain_in[3] = sha1sh_pkg::Init3;
                  chain_in[4] = sha1sh_pkg::Init4;
                  count_in    = '0;
                  state_in    = StIdle;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= StIdle;
         count_ff    <= '0;
         chain_ff[0] <= sha1sh_pkg::Init0;
         chain_ff[1] <= sha1sh_pkg::Init1;
         chain_ff[2] <= sha1sh_pkg::Init2;
         chain_ff[3] <= sha1sh_pkg::Init3;
         chain_ff[4] <= sha1sh_pkg::Init4;
         rnd_ff      <= '0;
         oi_ff       <= '0;
         fin_ff      <= 1'b0;
         first_ff    <= 1'b0;
         len_blk_ff  <= 1'b0;
         pw_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         chain_ff   <= chain_in;
         rnd_ff     <= rnd_in;
         oi_ff      <= oi_in;
         fin_ff     <= fin_in;
         first_ff   <= first_in;
         len_blk_ff <= len_blk_in;
         pw_ff      <= pw_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
      e_ff    <= e_in;
      win_ff  <= win_in;
      word_ff <= word_in;
   end

   // After the final digest word is transferred the block is idle again.
   assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_last_word |=> !rsp_valid && !req_stall)
      else $error("digest output did not end after the last word");

   // The round counter never passes the last round.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == StRound |-> rnd_ff < 7'(sha1sh_pkg::NumRounds))
      else $error("round counter out of range");

   // An absorb transfer advances the byte count by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_func == sha1sh_pkg::FuncAbsorb |=>
      count_ff == $past(count_ff) + 1'b1)
      else $error("byte count did not advance on absorb");

   // A full block always starts a compression.
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_func == sha1sh_pkg::FuncAbsorb && pos == 6'd63 |=>
      state_ff == StLoad)
      else $error("full block not compressed");

endmodule
